/* sv/bwsm_pkg.sv */
// Shared types, constants and helper functions of the binary-weight stripe MAC.
package bwsm_pkg;

    localparam int LANES     = 8;
    localparam int SLOTS     = 64;
    localparam int ACC_WIDTH = 32;

    localparam int LANE_W    = (LANES > 1) ? $clog2(LANES) : 1;
    localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int ACC_AW    = SLOT_W + LANE_W;
    localparam int ACC_DEPTH = SLOTS << LANE_W;
    localparam int SUM_W     = 9 + LANE_W;

    localparam int ROW_W     = 8;
    localparam int DATA_W    = 64;
    localparam int SLOTF_W   = 6;
    localparam int LANEF_W   = 3;
    localparam int OUT_W     = 32;

    typedef enum logic [1:0] {
        MODE_LOAD = 2'd0,
        MODE_SWAP = 2'd1,
        MODE_ACC  = 2'd2,
        MODE_READ = 2'd3
    } t_mode;

    typedef struct packed {
        t_mode                mode;
        logic [ROW_W-1:0]     weight_row;
        logic [DATA_W-1:0]    data_word;
        logic [SLOTF_W-1:0]   slot;
        logic                 accumulate;
    } t_in_item;

    typedef struct packed {
        logic [LANEF_W-1:0]   lane;
        logic signed [OUT_W-1:0] acc_value;
        logic                 last;
    } t_out_item;

    typedef struct packed {
        logic             load;
        logic             swap;
        logic [LANES-1:0] row;
    } t_bank_ctrl;

    // Signed sum of the activations with +1/-1 weights given by the row bits.
    function automatic logic [ACC_WIDTH-1:0] lane_dot(
        input logic [LANES-1:0]  row,
        input logic [DATA_W-1:0] data
    );
        logic signed [SUM_W-1:0] s;
        logic signed [SUM_W-1:0] term;
        s = '0;
        for (int p = 0; p < LANES; p++) begin
            term = SUM_W'($signed(data[8*p +: 8]));
            if (row[p]) begin
                s = s + term;
            end else begin
                s = s - term;
            end
        end
        return ACC_WIDTH'(s);
    endfunction

    function automatic logic signed [OUT_W-1:0] acc_to_out(input logic [ACC_WIDTH-1:0] v);
        return OUT_W'($signed(v));
    endfunction

endpackage

/* sv/bwsm_weight_bank.sv */
// Double-buffered weight rows: shadow bank loaded by shifting, active bank read per lane.
module bwsm_weight_bank
    import bwsm_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_bank_ctrl       i_ctrl,
    input  logic [LANE_W-1:0] i_lane,
    output logic [LANES-1:0] o_row
);

    logic [LANES-1:0] r_bank_a [LANES];
    logic [LANES-1:0] r_bank_b [LANES];
    logic             r_active;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            for (int q = 0; q < LANES; q++) begin
                r_bank_a[q] <= '0;
                r_bank_b[q] <= '0;
            end
        end else begin
            if (i_ctrl.swap) begin
                r_active <= ~r_active;
            end
            if (i_ctrl.load) begin
                // The shadow bank shifts down one row and takes the new row on top.
                if (r_active) begin
                    for (int q = 0; q < LANES - 1; q++) begin
                        r_bank_b[q] <= r_bank_b[q+1];
                    end
                    r_bank_b[LANES-1] <= i_ctrl.row;
                end else begin
                    for (int q = 0; q < LANES - 1; q++) begin
                        r_bank_a[q] <= r_bank_a[q+1];
                    end
                    r_bank_a[LANES-1] <= i_ctrl.row;
                end
            end
        end
    end

    assign o_row = r_active ? r_bank_a[i_lane] : r_bank_b[i_lane];

endmodule

/* sv/bwsm_acc_ram.sv */
// Accumulator storage: one lane value per entry, one write and one registered read per cycle.
module bwsm_acc_ram
    import bwsm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [ACC_AW-1:0]    i_waddr,
    input  logic [ACC_WIDTH-1:0] i_wdata,
    input  logic                 i_re,
    input  logic [ACC_AW-1:0]    i_raddr,
    output logic [ACC_WIDTH-1:0] o_rdata
);

    logic [ACC_WIDTH-1:0] r_mem [ACC_DEPTH];
    logic [ACC_WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/binary_weight_stripe_mac_core.sv */
// Top level of the binary-weight stripe MAC: command sequencer around the accumulator RAM.
//
// Usage: a command is transferred on i_item at a rising edge where start is high and
// busy is low. Mode 0 shifts weight_row into the shadow weight bank and mode 1 swaps
// the shadow and active banks; both finish at the transfer edge and leave busy low.
// Mode 2 forms the +/- activation sum for each output lane and writes or adds it into
// the named slot; busy stays high after the transfer while one lane is handled per
// cycle, and the last write-back lands in the following cycle. Mode 3 reads the slot
// out: busy stays high while the lanes are read, and the lane results appear on o_result
// with o_valid high for one cycle each, lane 0 first. The first lane is strobed once the
// sequencer state and then the RAM read data and o_valid registers have been loaded, and
// last is set on the final lane. The receiver cannot stall; every strobed result is
// taken. The sequencer handles one lane per cycle, set by the single read and single
// write port of the accumulator RAM, and returns to idle after the last lane, where it
// takes the next transfer; modes 0 and 1 never leave idle. Reset clears both weight
// banks, selects bank B as active and idles the sequencer; accumulator slots hold no
// defined value until first written.
module binary_weight_stripe_mac_core
    import bwsm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_item  i_item,
    output logic      o_valid,
    output t_out_item o_result
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ACC,
        ST_READ
    } t_state;

    t_state                r_state,   n_state;
    logic [LANE_W-1:0]     r_lane,    n_lane;
    logic [SLOT_W-1:0]     r_slot,    n_slot;
    logic                  r_acc_en,  n_acc_en;
    logic [DATA_W-1:0]     r_data,    n_data;
    logic                  r_wr_valid, n_wr_valid;
    logic                  r_wr_add,  n_wr_add;
    logic [ACC_AW-1:0]     r_wr_addr, n_wr_addr;
    logic [ACC_WIDTH-1:0]  r_sum,     n_sum;
    logic                  r_rd_valid, n_rd_valid;
    logic [LANE_W-1:0]     r_rd_lane, n_rd_lane;
    logic                  r_rd_last, n_rd_last;

    logic                  accept;
    logic                  lane_end;
    t_bank_ctrl            bank_ctrl;
    logic [LANES-1:0]      act_row;
    logic                  ram_re;
    logic [ACC_AW-1:0]     ram_raddr;
    logic [ACC_WIDTH-1:0]  ram_rdata;
    logic [ACC_WIDTH-1:0]  ram_wdata;

    assign busy     = (r_state != ST_IDLE);
    assign accept   = start && !busy;
    assign lane_end = (r_lane == LANE_W'(LANES - 1));

    // Weight loads and swaps take effect right at the transfer edge.
    always_comb begin
        bank_ctrl.load = accept && (i_item.mode == MODE_LOAD);
        bank_ctrl.swap = accept && (i_item.mode == MODE_SWAP);
        bank_ctrl.row  = i_item.weight_row[LANES-1:0];
    end

    bwsm_weight_bank u_bank (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (bank_ctrl),
        .i_lane  (r_lane),
        .o_row   (act_row)
    );

    // One lane entry is read per cycle; the write-back of the previous lane runs
    // alongside it, always at a different lane, so no forwarding is needed.
    assign ram_re    = (r_state == ST_ACC) || (r_state == ST_READ);
    assign ram_raddr = {r_slot, r_lane};
    assign ram_wdata = r_wr_add ? (ram_rdata + r_sum) : r_sum;

    bwsm_acc_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (r_wr_valid),
        .i_waddr (r_wr_addr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state    = r_state;
        n_lane     = r_lane;
        n_slot     = r_slot;
        n_acc_en   = r_acc_en;
        n_data     = r_data;
        n_wr_valid = 1'b0;
        n_wr_add   = r_acc_en;
        n_wr_addr  = ram_raddr;
        n_sum      = lane_dot(act_row, r_data);
        n_rd_valid = 1'b0;
        n_rd_lane  = r_lane;
        n_rd_last  = lane_end;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_lane   = '0;
                    n_slot   = SLOT_W'(i_item.slot);
                    n_acc_en = i_item.accumulate;
                    n_data   = i_item.data_word;
                    if (i_item.mode == MODE_ACC) begin
                        n_state = ST_ACC;
                    end else if (i_item.mode == MODE_READ) begin
                        n_state = ST_READ;
                    end
                end
            end
            ST_ACC: begin
                n_wr_valid = 1'b1;
                n_lane     = r_lane + LANE_W'(1);
                if (lane_end) begin
                    n_state = ST_IDLE;
                end
            end
            ST_READ: begin
                n_rd_valid = 1'b1;
                n_lane     = r_lane + LANE_W'(1);
                if (lane_end) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_wr_valid <= 1'b0;
            r_rd_valid <= 1'b0;
            r_lane     <= '0;
        end else begin
            r_state    <= n_state;
            r_wr_valid <= n_wr_valid;
            r_rd_valid <= n_rd_valid;
            r_lane     <= n_lane;
        end
        r_slot    <= n_slot;
        r_acc_en  <= n_acc_en;
        r_data    <= n_data;
        r_wr_add  <= n_wr_add;
        r_wr_addr <= n_wr_addr;
        r_sum     <= n_sum;
        r_rd_lane <= n_rd_lane;
        r_rd_last <= n_rd_last;
    end

    assign o_valid            = r_rd_valid;
    assign o_result.lane      = LANEF_W'(r_rd_lane);
    assign o_result.acc_value = acc_to_out(ram_rdata);
    assign o_result.last      = r_rd_last;

    // A readout and an accumulate write-back never overlap.
    a_no_rd_wr_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_wr_valid && r_rd_valid))
        else $error("accumulate write-back overlaps a readout");

    // A readout streams its lanes back to back until the last one.
    a_readout_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_result.last) |=> o_valid)
        else $error("readout interrupted before the last lane");

    // Nothing is strobed directly after the last lane of a readout.
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.last) |=> !o_valid)
        else $error("result strobed after the last lane");

    // An accepted accumulate or read command keeps the block busy.
    a_busy_after_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_item.mode == MODE_ACC || i_item.mode == MODE_READ)) |=> busy)
        else $error("busy not raised after an accumulate or read transfer");

endmodule
